/* rtl/fts_pkg.sv */
// ----------------------------------------------------------------------------
// fts_pkg
// types and codes shared by the frame timer scheduler and its checker
// ----------------------------------------------------------------------------
package fts_pkg;

	localparam logic [2:0] OP_SCHEDULE   = 3'd0;
	localparam logic [2:0] OP_CANCEL     = 3'd1;
	localparam logic [2:0] OP_CANCEL_ALL = 3'd2;
	localparam logic [2:0] OP_TICK       = 3'd3;
	localparam logic [2:0] OP_REPORT     = 3'd4;

	localparam logic [1:0] KIND_REPLY   = 2'd0;
	localparam logic [1:0] KIND_FIRED   = 2'd1;
	localparam logic [1:0] KIND_SUMMARY = 2'd2;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_INVALID  = 2'd1;
	localparam logic [1:0] ST_RESOURCE = 2'd2;
	localparam logic [1:0] ST_HANDLE   = 2'd3;

	typedef struct packed {
		logic [2:0]         operation;
		logic [7:0]         owner_id;
		logic               callback_present;
		logic [31:0]        delay_frames;
		logic [31:0]        interval_frames;
		logic [15:0]        load_order;
		logic signed [15:0] priority_level;
		logic [31:0]        timer_handle;
		logic               callback_failed;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  item_kind;
		logic [1:0]  status;
		logic [31:0] handle_out;
		logic [7:0]  owner_out;
		logic        retired;
		logic [6:0]  count_out;
		logic [31:0] frame_out;
		logic        last_item;
	} out_word_t;

	// one table entry as held in the memory
	typedef struct packed {
		logic [31:0] handle;
		logic [7:0]  owner;
		logic [15:0] load_order;
		logic [15:0] priority_level;
		logic [31:0] due_frame;
		logic [31:0] interval;
		logic [7:0]  failures;
	} entry_t;

endpackage

/* rtl/frame_timer_scheduler.sv */
// ----------------------------------------------------------------------------
// frame_timer_scheduler
// table of one-shot and periodic frame timers held in one memory
// ----------------------------------------------------------------------------
// channel   direction  handshake       payload
// in        input      in_valid/stall  fts_pkg::in_word_t
// out       output     out_valid/stall fts_pkg::out_word_t
// cfg       input      valid/ready     max_failures, 8 bits
//
// schedule is answered from the idle state; cancel and cancel-all sweep the
// table; a report sweeps and then rereads and writes back its entry; a tick
// makes one sweep per fired timer plus a last one, set by the one read port
// of the entry memory. valid bits sit in flip-flops cleared by reset, so no
// clearing pass is needed. one item is worked at a time; a word held by
// out_stall holds off the next item.
module frame_timer_scheduler #(
	parameter int MAX_TIMERS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  fts_pkg::in_word_t  in_word,
	output logic               out_valid,
	input  logic               out_stall,
	output fts_pkg::out_word_t out_word,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_data
);
	import fts_pkg::*;

	localparam int IW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
	localparam int CW = $clog2(MAX_TIMERS + 1);

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_SCAN_LAST, S_FIRE_RD, S_FIRE_WB, S_ONE_RD, S_ONE_WB, S_EMIT
	} state_t;

	state_t          state_q;
	in_word_t        req_q;
	logic [7:0]      max_fail_q;
	logic [31:0]     frame_q;
	logic [31:0]     next_handle_q;
	logic [MAX_TIMERS-1:0] valid_q;
	logic [MAX_TIMERS-1:0] due_q;   // still a candidate in this tick: valid, not found undue, not yet fired

	entry_t          mem [MAX_TIMERS];
	entry_t          rd_s1;
	logic [IW-1:0]   rd_addr;
	logic            wr_en;
	logic [IW-1:0]   wr_addr;
	entry_t          wr_data;

	logic [CW-1:0]   scan_q;        // address being issued
	logic [IW-1:0]   tag_q;         // address of the data in rd_s1
	logic            tag_v_q;
	logic            best_v_q;
	logic [IW-1:0]   best_q;
	entry_t          best_e_q;
	logic [6:0]      count_q;
	logic            hit_q;
	logic [IW-1:0]   hit_idx_q;
	out_word_t       obuf_q;
	logic            ovalid_q;

	logic [7:0]      limit;
	logic            free_v;
	logic [IW-1:0]   free_idx;

	assign limit     = (max_fail_q == 8'd0) ? 8'd1 : max_fail_q;
	assign in_stall  = (state_q != S_IDLE) || ovalid_q;
	assign cfg_ready = 1'b1;
	assign out_valid = ovalid_q;
	assign out_word  = obuf_q;

	// lowest free slot, priority over valid bits
	always_comb begin
		free_v   = 1'b0;
		free_idx = '0;
		for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_v   = 1'b1;
				free_idx = IW'(i);
			end
		end
	end

	// firing order: due, load order, biased priority, owner, handle
	function automatic logic fires_before(entry_t a, entry_t b);
		logic [15:0] pa, pb;
		pa = a.priority_level ^ 16'h8000;
		pb = b.priority_level ^ 16'h8000;
		if (a.due_frame != b.due_frame) return a.due_frame < b.due_frame;
		if (a.load_order != b.load_order) return a.load_order < b.load_order;
		if (pa != pb) return pa < pb;
		if (a.owner != b.owner) return a.owner < b.owner;
		return a.handle < b.handle;
	endfunction

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_s1 <= mem[rd_addr];
	end

	function automatic out_word_t mk(logic [1:0] k, logic [1:0] st, logic [31:0] h,
		logic [7:0] o, logic r, logic [6:0] c, logic [31:0] f, logic l);
		out_word_t w;
		w.item_kind = k; w.status = st; w.handle_out = h; w.owner_out = o;
		w.retired = r; w.count_out = c; w.frame_out = f; w.last_item = l;
		return w;
	endfunction

	logic [IW-1:0] tag_idx;
	logic          tag_match;
	assign tag_idx = tag_q;
	assign rd_addr = (state_q == S_FIRE_RD || state_q == S_ONE_RD) ? hit_idx_q
		: scan_q[IW-1:0];
	// scan hit for the data now in rd_s1
	always_comb begin
		tag_match = 1'b0;
		case (req_q.operation)
			OP_CANCEL, OP_REPORT: tag_match = valid_q[tag_idx] && req_q.timer_handle != 32'd0
				&& rd_s1.handle == req_q.timer_handle;
			OP_CANCEL_ALL: tag_match = valid_q[tag_idx] && rd_s1.owner == req_q.owner_id;
			OP_TICK: tag_match = due_q[tag_idx];
			default: tag_match = 1'b0;
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = hit_idx_q;
		wr_data = best_e_q;
		if (state_q == S_IDLE && in_valid && !in_stall && in_word.operation == OP_SCHEDULE) begin
			wr_en   = free_v;
			wr_addr = free_idx;
			wr_data.handle         = next_handle_q;
			wr_data.owner          = in_word.owner_id;
			wr_data.load_order     = in_word.load_order;
			wr_data.priority_level = in_word.priority_level;
			wr_data.due_frame      = frame_q + in_word.delay_frames;
			wr_data.interval       = in_word.interval_frames;
			wr_data.failures       = 8'd0;
		end else if (state_q == S_FIRE_WB) begin
			wr_en   = 1'b1;
			wr_addr = best_q;
			wr_data = rd_s1;
			wr_data.due_frame = rd_s1.due_frame + rd_s1.interval;
		end else if (state_q == S_ONE_WB) begin
			wr_en   = 1'b1;
			wr_data = rd_s1;
			if (!req_q.callback_failed) wr_data.failures = 8'd0;
			else if (rd_s1.failures != 8'hFF) wr_data.failures = rd_s1.failures + 8'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			max_fail_q    <= 8'd1;
			frame_q       <= '0;
			next_handle_q <= 32'd1;
			valid_q       <= '0;
			due_q         <= '0;
			ovalid_q      <= 1'b0;
			scan_q        <= '0;
			tag_q         <= '0;
			tag_v_q       <= 1'b0;
			best_v_q      <= 1'b0;
			best_q        <= '0;
			count_q       <= '0;
			hit_q         <= 1'b0;
			hit_idx_q     <= '0;
		end else begin
			if (cfg_valid) max_fail_q <= cfg_data;
			// the summary state reloads the output register itself
			if (ovalid_q && !out_stall && state_q != S_EMIT) ovalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid && !in_stall) begin
						req_q    <= in_word;
						scan_q   <= '0;
						tag_v_q  <= 1'b0;
						hit_q    <= 1'b0;
						best_v_q <= 1'b0;
						count_q  <= '0;
						case (in_word.operation)
							OP_SCHEDULE: begin
								ovalid_q <= 1'b1;
								if (in_word.owner_id == 8'd0 || !in_word.callback_present
									|| in_word.delay_frames == 32'd0)
									obuf_q <= mk(KIND_REPLY, ST_INVALID, '0, '0, 1'b0, '0, frame_q, 1'b1);
								else if (in_word.delay_frames > ~frame_q || &next_handle_q
									|| !free_v)
									obuf_q <= mk(KIND_REPLY, ST_RESOURCE, '0, '0, 1'b0, '0, frame_q, 1'b1);
								else begin
									valid_q[free_idx] <= 1'b1;
									next_handle_q     <= next_handle_q + 32'd1;
									obuf_q <= mk(KIND_REPLY, ST_OK, next_handle_q, '0, 1'b0, '0, frame_q, 1'b1);
								end
							end
							OP_CANCEL, OP_REPORT: state_q <= S_SCAN;
							OP_CANCEL_ALL: begin
								if (in_word.owner_id == 8'd0) begin
									ovalid_q <= 1'b1;
									obuf_q <= mk(KIND_REPLY, ST_INVALID, '0, '0, 1'b0, '0, frame_q, 1'b1);
								end else state_q <= S_SCAN;
							end
							OP_TICK: begin
								if (&frame_q) begin
									ovalid_q <= 1'b1;
									obuf_q <= mk(KIND_REPLY, ST_RESOURCE, '0, '0, 1'b0, '0, frame_q, 1'b1);
								end else begin
									frame_q <= frame_q + 32'd1;
									due_q   <= '1 & valid_q;
									state_q <= S_SCAN;
								end
							end
							default: begin
								ovalid_q <= 1'b1;
								obuf_q <= mk(KIND_REPLY, ST_INVALID, '0, '0, 1'b0, '0, frame_q, 1'b1);
							end
						endcase
					end
				end
				S_SCAN: begin
					// issue one read a cycle, judge the previous one
					tag_q   <= scan_q[IW-1:0];
					tag_v_q <= 1'b1;
					if (scan_q == CW'(MAX_TIMERS - 1)) state_q <= S_SCAN_LAST;
					else scan_q <= scan_q + CW'(1);
					if (tag_v_q) begin
						if (req_q.operation == OP_TICK && due_q[tag_idx]
							&& rd_s1.due_frame > frame_q)
							due_q[tag_idx] <= 1'b0;
					end
					if (tag_v_q && tag_match) begin
						case (req_q.operation)
							OP_CANCEL_ALL: begin
								valid_q[tag_idx] <= 1'b0;
								count_q <= count_q + 7'd1;
							end
							OP_TICK: begin
								if (rd_s1.due_frame <= frame_q
									&& (!best_v_q || fires_before(rd_s1, best_e_q))) begin
									best_v_q <= 1'b1;
									best_q   <= tag_idx;
									best_e_q <= rd_s1;
								end
							end
							default: begin
								hit_q     <= 1'b1;
								hit_idx_q <= tag_idx;
								best_e_q  <= rd_s1;
							end
						endcase
					end
				end
				S_SCAN_LAST: begin
					// judge the last entry, then finish
					logic h_last, due_last;
					logic [IW-1:0] b_idx;
					entry_t b_e;
					logic b_v;
					logic [MAX_TIMERS-1:0] due_n;
					due_last = req_q.operation == OP_TICK && due_q[tag_idx]
						&& rd_s1.due_frame <= frame_q;
					h_last = tag_match && (req_q.operation != OP_TICK || due_last);
					due_n = due_q;
					if (req_q.operation == OP_TICK && due_q[tag_idx] && !due_last)
						due_n[tag_idx] = 1'b0;
					b_v = best_v_q; b_idx = best_q; b_e = best_e_q;
					if (due_last && (!best_v_q || fires_before(rd_s1, best_e_q))) begin
						b_v = 1'b1; b_idx = tag_idx; b_e = rd_s1;
					end
					tag_v_q <= 1'b0;
					scan_q  <= '0;
					case (req_q.operation)
						OP_CANCEL_ALL: begin
							logic [6:0] n;
							n = count_q + (h_last ? 7'd1 : 7'd0);
							if (h_last) valid_q[tag_idx] <= 1'b0;
							ovalid_q <= 1'b1;
							obuf_q <= mk(KIND_REPLY, ST_OK, '0, req_q.owner_id, n != 7'd0, n,
								frame_q, 1'b1);
							state_q <= S_IDLE;
						end
						OP_TICK: begin
							best_v_q <= 1'b0;
							if (b_v) begin
								best_q    <= b_idx;
								best_e_q  <= b_e;
								hit_idx_q <= b_idx;
								due_n[b_idx] = 1'b0;
								state_q   <= S_FIRE_RD;
							end else begin
								state_q <= S_EMIT;
							end
						end
						default: begin
							logic hh;
							logic [IW-1:0] hi;
							entry_t he;
							hh = hit_q || h_last;
							hi = h_last ? tag_idx : hit_idx_q;
							he = h_last ? rd_s1 : best_e_q;
							hit_idx_q <= hi;
							if (!hh) begin
								ovalid_q <= 1'b1;
								obuf_q <= mk(KIND_REPLY, ST_HANDLE, '0, '0, 1'b0, '0, frame_q, 1'b1);
								state_q <= S_IDLE;
							end else if (req_q.operation == OP_CANCEL) begin
								valid_q[hi] <= 1'b0;
								ovalid_q <= 1'b1;
								obuf_q <= mk(KIND_REPLY, ST_OK, he.handle, he.owner, 1'b1, 7'd1,
									frame_q, 1'b1);
								state_q <= S_IDLE;
							end else begin
								state_q <= S_ONE_RD;
							end
						end
					endcase
					due_q <= due_n;
				end
				S_ONE_RD: state_q <= S_ONE_WB;
				S_ONE_WB: begin
					logic [7:0] nf;
					logic       r;
					nf = (rd_s1.failures != 8'hFF) ? rd_s1.failures + 8'd1 : rd_s1.failures;
					r  = req_q.callback_failed && (rd_s1.interval == 32'd0 || nf >= limit);
					if (r) valid_q[hit_idx_q] <= 1'b0;
					ovalid_q <= 1'b1;
					obuf_q <= mk(KIND_REPLY, ST_OK, rd_s1.handle, rd_s1.owner, r, '0, frame_q, 1'b1);
					state_q <= S_IDLE;
				end
				S_FIRE_RD: begin
					// wait for the output register before showing a fired word
					if (!ovalid_q || !out_stall) state_q <= S_FIRE_WB;
				end
				S_FIRE_WB: begin
					logic r;
					r = rd_s1.interval == 32'd0 || rd_s1.due_frame > ~rd_s1.interval;
					if (r) valid_q[best_q] <= 1'b0;
					ovalid_q <= 1'b1;
					obuf_q <= mk(KIND_FIRED, ST_OK, rd_s1.handle, rd_s1.owner, r, '0, frame_q, 1'b0);
					count_q <= count_q + 7'd1;
					state_q <= S_SCAN;
				end
				S_EMIT: begin
					if (!ovalid_q || !out_stall) begin
						ovalid_q <= 1'b1;
						obuf_q <= mk(KIND_SUMMARY, ST_OK, '0, '0, 1'b0, count_q, frame_q, 1'b1);
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* rtl/fts_checker.sv */
// ----------------------------------------------------------------------------
// fts_checker
// port-level checks of the frame timer scheduler
// ----------------------------------------------------------------------------
module fts_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input fts_pkg::out_word_t out_word
);
	import fts_pkg::*;

	// a stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("stalled word changed");

	// a summary always closes its input
	a_sum_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.item_kind == KIND_SUMMARY |-> out_word.last_item)
		else $error("summary not last");

	// a fired word never closes its input
	a_fire: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.item_kind == KIND_FIRED |-> !out_word.last_item)
		else $error("fired word marked last");

	// no input taken while a word waits
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input accepted with a word pending");

endmodule

bind frame_timer_scheduler fts_checker u_fts_checker (
	.clk(clk), .arst_n(arst_n), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
);

/* tb/tb_frame_timer_scheduler.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frame_timer_scheduler
// self-checking bench for the frame timer scheduler: a directed table of
// operations, then random schedule/tick/cancel/cancel-all/report traffic checked
// word by word against a behavioral timer table kept in the bench
// ----------------------------------------------------------------------------
module tb_frame_timer_scheduler;
	import fts_pkg::*;

	localparam int NSLOT     = 16;
	localparam int CYC_LIMIT = 400000;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	in_word_t  in_word = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_word_t out_word;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	logic [7:0] cfg_data = 8'd1;

	frame_timer_scheduler #(.MAX_TIMERS(NSLOT)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
		.out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// behavioral copy of the timer table
	logic [7:0]  fail_limit;
	logic        tv_valid  [NSLOT];
	logic [31:0] tv_handle [NSLOT];
	logic [7:0]  tv_owner  [NSLOT];
	logic [15:0] tv_load   [NSLOT];
	logic [15:0] tv_prio   [NSLOT];
	logic [31:0] tv_due    [NSLOT];
	logic [31:0] tv_ival   [NSLOT];
	logic [7:0]  tv_fails  [NSLOT];
	logic [31:0] cur_frame;
	logic [31:0] handle_ctr;

	out_word_t pending_words[$];
	int        mismatches = 0;
	int        cycles = 0;
	bit        quiet_stall = 1'b0;
	bit        quiet_send = 1'b0;

	function automatic out_word_t reply(logic [1:0] st, logic [31:0] h, logic [7:0] own,
			logic ret, logic [6:0] cnt);
		out_word_t w;
		w = '0;
		w.item_kind  = KIND_REPLY;
		w.status     = st;
		w.handle_out = h;
		w.owner_out  = own;
		w.retired    = ret;
		w.count_out  = cnt;
		w.frame_out  = cur_frame;
		w.last_item  = 1'b1;
		return w;
	endfunction

	// firing order: due frame, load order, signed priority, owner, handle
	function automatic bit fires_first(int a, int b);
		if (tv_due[a] != tv_due[b]) return tv_due[a] < tv_due[b];
		if (tv_load[a] != tv_load[b]) return tv_load[a] < tv_load[b];
		if (tv_prio[a] != tv_prio[b]) return $signed(tv_prio[a]) < $signed(tv_prio[b]);
		if (tv_owner[a] != tv_owner[b]) return tv_owner[a] < tv_owner[b];
		return tv_handle[a] < tv_handle[b];
	endfunction

	function automatic int slot_of(logic [31:0] h);
		if (h == 0) return -1;
		for (int i = 0; i < NSLOT; i++)
			if (tv_valid[i] && tv_handle[i] == h) return i;
		return -1;
	endfunction

	task automatic table_reset();
		fail_limit = 8'd1;
		for (int i = 0; i < NSLOT; i++) tv_valid[i] = 1'b0;
		cur_frame = 0;
		handle_ctr = 1;
	endtask

	// append one expected word
	task automatic expect_word(out_word_t w);
		pending_words.insert(pending_words.size(), w);
	endtask

	// apply one operation to the table, queue the words it should produce
	task automatic timer_table_step(in_word_t w);
		int s;
		int best;
		int n;
		logic ret;
		logic [7:0] lim;
		bit due [NSLOT];
		out_word_t f;
		lim = (fail_limit == 0) ? 8'd1 : fail_limit;
		case (w.operation)
		OP_SCHEDULE: begin
			s = -1;
			for (int i = NSLOT - 1; i >= 0; i--) if (!tv_valid[i]) s = i;
			if (w.owner_id == 0 || !w.callback_present || w.delay_frames == 0)
				expect_word(reply(ST_INVALID, 0, 0, 0, 0));
			else if (w.delay_frames > 32'hFFFF_FFFF - cur_frame ||
					handle_ctr == 32'hFFFF_FFFF || s < 0)
				expect_word(reply(ST_RESOURCE, 0, 0, 0, 0));
			else begin
				tv_valid[s]  = 1'b1;
				tv_handle[s] = handle_ctr;
				tv_owner[s]  = w.owner_id;
				tv_load[s]   = w.load_order;
				tv_prio[s]   = w.priority_level;
				tv_due[s]    = cur_frame + w.delay_frames;
				tv_ival[s]   = w.interval_frames;
				tv_fails[s]  = 0;
				handle_ctr++;
				expect_word(reply(ST_OK, tv_handle[s], 0, 0, 0));
			end
		end
		OP_CANCEL: begin
			s = slot_of(w.timer_handle);
			if (s < 0) expect_word(reply(ST_HANDLE, 0, 0, 0, 0));
			else begin
				tv_valid[s] = 1'b0;
				expect_word(reply(ST_OK, tv_handle[s], tv_owner[s], 1, 1));
			end
		end
		OP_CANCEL_ALL: begin
			n = 0;
			if (w.owner_id == 0) expect_word(reply(ST_INVALID, 0, 0, 0, 0));
			else begin
				for (int i = 0; i < NSLOT; i++)
					if (tv_valid[i] && tv_owner[i] == w.owner_id) begin
						tv_valid[i] = 1'b0;
						n++;
					end
				expect_word(reply(ST_OK, 0, w.owner_id, n != 0, 7'(n)));
			end
		end
		OP_TICK: begin
			if (cur_frame == 32'hFFFF_FFFF)
				expect_word(reply(ST_RESOURCE, 0, 0, 0, 0));
			else begin
				cur_frame++;
				n = 0;
				for (int i = 0; i < NSLOT; i++) due[i] = tv_valid[i] && tv_due[i] <= cur_frame;
				forever begin
					best = -1;
					for (int i = 0; i < NSLOT; i++)
						if (due[i] && (best < 0 || fires_first(i, best))) best = i;
					if (best < 0) break;
					due[best] = 1'b0;
					ret = tv_ival[best] == 0 ||
						tv_due[best] > 32'hFFFF_FFFF - tv_ival[best];
					if (ret) tv_valid[best] = 1'b0;
					else tv_due[best] += tv_ival[best];
					f = reply(ST_OK, tv_handle[best], tv_owner[best], ret, 0);
					f.item_kind = KIND_FIRED;
					f.last_item = 1'b0;
					expect_word(f);
					n++;
				end
				f = reply(ST_OK, 0, 0, 0, 7'(n));
				f.item_kind = KIND_SUMMARY;
				expect_word(f);
			end
		end
		OP_REPORT: begin
			s = slot_of(w.timer_handle);
			ret = 1'b0;
			if (s < 0) expect_word(reply(ST_HANDLE, 0, 0, 0, 0));
			else begin
				if (w.callback_failed) begin
					if (tv_fails[s] != 8'hFF) tv_fails[s]++;
					ret = tv_ival[s] == 0 || tv_fails[s] >= lim;
				end else tv_fails[s] = 0;
				if (ret) tv_valid[s] = 1'b0;
				expect_word(reply(ST_OK, tv_handle[s], tv_owner[s], ret, 0));
			end
		end
		default: expect_word(reply(ST_INVALID, 0, 0, 0, 0));
		endcase
	endtask

	// result side: compare each accepted word with the oldest expectation
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected word %p", out_word);
			end else begin
				if (out_word !== pending_words[0]) begin
					mismatches++;
					if (mismatches <= 10)
						$display("word mismatch: expected %p got %p", pending_words[0], out_word);
				end
				void'(pending_words.pop_front());
			end
		end
		if (cycles > CYC_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// receiver stall, drawn at random at each falling edge; held low while quiet_stall is set
	always @(negedge clk)
		out_stall <= quiet_stall ? 1'b0 : ($urandom_range(99) < 7);

	in_word_t directed_rows[$];
	out_word_t directed_want[$];
	bit        directed_typed[$];

	task automatic add_row(in_word_t r, out_word_t want, bit typed);
		directed_rows.insert(directed_rows.size(), r);
		directed_want.insert(directed_want.size(), want);
		directed_typed.insert(directed_typed.size(), typed);
	endtask

	// hand-read reply at frame 1
	function automatic out_word_t want_reply(logic [1:0] st, logic [31:0] h);
		return {KIND_REPLY, st, h, 8'd0, 1'b0, 7'd0, 32'd1, 1'b1};
	endfunction

	// starts and ends at a falling edge; valid stays up for a word sent right after
	task automatic send_word(in_word_t w);
		while (!quiet_send && $urandom_range(99) < 7) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_word  <= w;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		timer_table_step(w);
		@(negedge clk);
	endtask

	task automatic wait_empty();
		in_valid <= 1'b0;
		while (pending_words.size() != 0) @(negedge clk);
	endtask

	task automatic drain();
		wait_empty();
		repeat (NSLOT * 20) @(negedge clk);
	endtask

	task automatic write_limit(logic [7:0] v);
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		fail_limit = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic in_word_t op_word(logic [2:0] op, logic [7:0] own, logic cb,
			logic [31:0] dly, logic [31:0] iv, logic [31:0] h, logic failed);
		in_word_t w;
		w = '0;
		w.operation        = op;
		w.owner_id         = own;
		w.callback_present = cb;
		w.delay_frames     = dly;
		w.interval_frames  = iv;
		w.timer_handle     = h;
		w.callback_failed  = failed;
		return w;
	endfunction

	function automatic in_word_t rand_word();
		in_word_t w;
		int pick;
		w.operation        = 3'($urandom_range(4));
		w.owner_id         = 8'($urandom_range(1, 6));
		w.callback_present = 1'b1;
		w.delay_frames     = 32'($urandom_range(1, 5));
		w.interval_frames  = ($urandom_range(2) == 0) ? 32'd0 : 32'($urandom_range(1, 4));
		w.load_order       = ($urandom_range(1) == 0) ? 16'($urandom_range(2)) : 16'($urandom);
		w.priority_level   = ($urandom_range(1) == 0) ? 16'($urandom_range(2)) : 16'($urandom);
		w.timer_handle     = (handle_ctr > 1) ? 32'($urandom_range(1, handle_ctr)) : 32'd1;
		w.callback_failed  = 1'($urandom);
		pick = $urandom_range(99);
		// noise: wide fields, bad arguments, stray operation codes
		if (pick < 5) begin
			w.delay_frames    = $urandom;
			w.interval_frames = $urandom;
			w.timer_handle    = $urandom;
		end else if (pick < 8) w.owner_id = ($urandom_range(1) == 0) ? 8'd0 : 8'($urandom);
		else if (pick < 10) w.callback_present = 1'b0;
		else if (pick < 12) w.operation = 3'($urandom_range(5, 7));
		if (w.operation == OP_TICK && $urandom_range(1)) w.operation = OP_SCHEDULE;
		return w;
	endfunction

	initial begin
		in_word_t w;
		logic [7:0] lims [4];
		table_reset();
		lims = '{8'd0, 8'd255, 8'd2, 8'd1};
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table; rows marked typed carry a hand-read expectation
		add_row(op_word(OP_TICK, 0, 0, 0, 0, 0, 0), '0, 1'b0);
		add_row(op_word(OP_SCHEDULE, 0, 1, 5, 0, 0, 0), want_reply(ST_INVALID, 0), 1'b1);
		add_row(op_word(OP_SCHEDULE, 8'hFF, 0, 5, 0, 0, 0), want_reply(ST_INVALID, 0), 1'b1);
		add_row(op_word(OP_SCHEDULE, 8'd3, 1, 0, 0, 0, 0), want_reply(ST_INVALID, 0), 1'b1);
		add_row(op_word(OP_SCHEDULE, 8'd3, 1, 32'hFFFF_FFFF, 0, 0, 0),
			want_reply(ST_RESOURCE, 0), 1'b1);
		add_row(op_word(OP_SCHEDULE, 8'd3, 1, 32'hFFFF_FFFE, 0, 0, 0),
			want_reply(ST_OK, 32'd1), 1'b1);
		add_row(op_word(OP_CANCEL, 0, 0, 0, 0, 0, 0), want_reply(ST_HANDLE, 0), 1'b1);
		add_row(op_word(OP_CANCEL, 0, 0, 0, 0, 32'hFFFF_FFFF, 0),
			want_reply(ST_HANDLE, 0), 1'b1);
		add_row(op_word(OP_CANCEL_ALL, 0, 0, 0, 0, 0, 0), want_reply(ST_INVALID, 0), 1'b1);
		add_row(op_word(OP_REPORT, 0, 0, 0, 0, 0, 1), want_reply(ST_HANDLE, 0), 1'b1);
		add_row(op_word(3'd7, 0, 0, 0, 0, 0, 0), want_reply(ST_INVALID, 0), 1'b1);
		// periodic with huge interval retires on its first fire; ties broken by keys
		add_row(op_word(OP_SCHEDULE, 8'd9, 1, 1, 32'hFFFF_FFFF, 0, 0), '0, 1'b0);
		add_row(op_word(OP_SCHEDULE, 8'd2, 1, 1, 0, 0, 0), '0, 1'b0);
		add_row(op_word(OP_SCHEDULE, 8'd2, 1, 1, 1, 0, 0), '0, 1'b0);
		add_row(op_word(OP_TICK, 0, 0, 0, 0, 0, 0), '0, 1'b0);
		add_row(op_word(OP_REPORT, 0, 0, 0, 0, 32'd4, 0), '0, 1'b0);
		add_row(op_word(OP_REPORT, 0, 0, 0, 0, 32'd4, 1), '0, 1'b0);
		add_row(op_word(OP_CANCEL, 0, 0, 0, 0, 32'd1, 0), '0, 1'b0);
		add_row(op_word(OP_CANCEL_ALL, 8'd2, 0, 0, 0, 0, 0), '0, 1'b0);
		directed_rows[12].load_order     = 16'hFFFF;
		directed_rows[13].priority_level = 16'sh8000;
		directed_rows[11].priority_level = 16'sh7FFF;

		for (int i = 0; i < directed_rows.size(); i++) begin
			send_word(directed_rows[i]);
			if (directed_typed[i] && pending_words[$] !== directed_want[i]) begin
				mismatches++;
				if (mismatches <= 10)
					$display("row %0d: expected %p, table gives %p",
						i, directed_want[i], pending_words[$]);
			end
		end
		drain();

		// random phases under several failure limits, extremes included
		foreach (lims[k]) begin
			write_limit(lims[k]);
			quiet_stall = (k == 2);
			quiet_send  = (k == 2);
			for (int j = 0; j < 23; j++) begin
				w = rand_word();
				send_word(w);
				if (j == 11) wait_empty();
			end
			drain();
		end

		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
